// File: rtl/ilir_pkg.sv
package ilir_pkg;

    // Request codes carried in the op field.
    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_WRITE  = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Action that every cell of the row takes.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_LOAD
    } t_cell_op;

    // Control broadcast along the row of cells.
    typedef struct packed {
        t_cell_op    op;
        logic [31:0] value;
    } t_cell_ctl;

endpackage

// File: rtl/ilir_cell.sv
module ilir_cell
    import ilir_pkg::*;
(
    input  logic        i_clk,
    input  t_cell_ctl   i_ctl,
    input  logic        i_at,
    input  logic        i_above,
    input  logic [31:0] i_left,
    input  logic [31:0] i_right,
    output logic [31:0] o_value
);

    logic [31:0] r_value;
    logic [31:0] n_value;

    // Pick the next entry: keep it, take a neighbor's, or take the new value.
    always_comb begin
        n_value = r_value;
        unique case (i_ctl.op)
            CELL_HOLD: begin
                n_value = r_value;
            end
            CELL_SHIFT_UP: begin
                if (i_above) begin
                    n_value = i_left;
                end else if (i_at) begin
                    n_value = i_ctl.value;
                end
            end
            CELL_SHIFT_DOWN: begin
                if (i_at || i_above) begin
                    n_value = i_right;
                end
            end
            CELL_LOAD: begin
                if (i_at) begin
                    n_value = i_ctl.value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // Entry register; its contents mean nothing until written.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// File: rtl/indexed_list_insert_remove.sv
// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells.
// Requests arrive on the s_axis channel: append, insert at a position,
// remove at a position, overwrite or read an entry. Each request yields
// exactly one result item on the m_axis channel with a status (ok, bad
// position, full), the data read (zero unless a read succeeds) and the
// list length after the request.
// The result becomes valid in the cycle after acceptance. One request is
// taken per cycle unless the receiver stalls with a result waiting: all
// cells shift or load in parallel in the cycle the request is accepted,
// and the length counter and the entry read mux settle in that same cycle.
// The result sits in an output register; while the receiver stalls,
// s_axis_tready stays low only if that register is full and not being
// taken, so a new request is taken in the same cycle a result leaves.
// A synchronous active-low reset empties the list (length zero) and drops
// any pending result; entry contents are not cleared and are never read
// before they are written.
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0 up: op, position, data_value.
    input  logic [(3 + $clog2(DEPTH + 1) + 32 + 7) / 8 * 8 - 1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0 up: status, read_data, list_length.
    output logic [(2 + 32 + $clog2(DEPTH + 1) + 7) / 8 * 8 - 1:0] m_axis_tdata
);

    localparam int LW     = $clog2(DEPTH + 1);
    localparam int AW     = $clog2(DEPTH);
    localparam int IN_W   = (3 + LW + 32 + 7) / 8 * 8;
    localparam int OUT_W  = (2 + 32 + LW + 7) / 8 * 8;
    localparam int IN_PAD = IN_W - (3 + LW + 32);

    // Unpack the request.
    logic [2:0]    w_op;
    logic [LW-1:0] w_pos;
    logic [31:0]   w_data;
    logic          w_in_acc;

    assign w_op     = s_axis_tdata[2:0];
    assign w_pos    = s_axis_tdata[3 +: LW];
    assign w_data   = s_axis_tdata[3 + LW +: 32];
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    // Length counter and result register.
    logic [LW-1:0] r_count;
    logic [LW-1:0] n_count;
    logic          r_out_valid;
    t_status       r_status;
    t_status       n_status;
    logic [31:0]   r_rdata;
    logic [31:0]   n_rdata;
    logic [LW-1:0] r_len;

    // Row of cells and its control.
    t_cell_ctl     w_ctl;
    logic [LW-1:0] w_tgt;
    logic [DEPTH-1:0] w_at;
    logic [DEPTH-1:0] w_above;
    logic [31:0]   w_cell [DEPTH];
    logic          w_full;

    assign w_full = (r_count == LW'(DEPTH));

    // Decode the request into a cell action, a status and the new length.
    always_comb begin
        w_ctl.op    = CELL_HOLD;
        w_ctl.value = w_data;
        w_tgt       = w_pos;
        n_count     = r_count;
        n_status    = ST_OK;
        n_rdata     = '0;
        unique case (w_op)
            OP_APPEND: begin
                w_tgt = r_count;
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.op = CELL_LOAD;
                    n_count  = r_count + 1'b1;
                end
            end
            OP_INSERT: begin
                if (w_pos > r_count) begin
                    n_status = ST_BAD_POS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.op = CELL_SHIFT_UP;
                    n_count  = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (w_pos >= r_count) begin
                    n_status = ST_BAD_POS;
                end else begin
                    w_ctl.op = CELL_SHIFT_DOWN;
                    n_count  = r_count - 1'b1;
                end
            end
            OP_WRITE: begin
                if (w_pos >= r_count) begin
                    n_status = ST_BAD_POS;
                end else begin
                    w_ctl.op = CELL_LOAD;
                end
            end
            OP_READ: begin
                if (w_pos >= r_count) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_rdata = w_cell[w_pos[AW-1:0]];
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        if (!w_in_acc) begin
            w_ctl.op = CELL_HOLD;
        end
    end

    // The cells; each compares its own place against the target position.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;

        assign w_at[g]    = (w_tgt == LW'(g));
        assign w_above[g] = (LW'(g) > w_tgt);

        if (g == 0) begin : g_first
            assign w_left = w_cell[g];
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        ilir_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_at    (w_at[g]),
            .i_above (w_above[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_cell[g])
        );
    end

    // Control state: length and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_status <= n_status;
            r_rdata  <= n_rdata;
            r_len    <= n_count;
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_len, r_rdata, r_status});

    // Padding bits of the request carry nothing.
    if (IN_PAD > 0) begin : g_in_pad
        logic w_in_pad_unused;
        assign w_in_pad_unused = |s_axis_tdata[IN_W-1 -: IN_PAD];
    end

    // The length never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(DEPTH))
        else $error("list length above capacity");

    // A full report always comes with a full list.
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (r_len == LW'(DEPTH)))
        else $error("full status with list not full");

    // Only a successful read returns data.
    a_rdata_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rdata != 32'd0) |-> (r_status == ST_OK))
        else $error("read data on a failed request");

    // Every accepted item leaves a result behind.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid)
        else $error("accepted item without result");

    // The length moves only on an accepted item.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_in_acc && $past(i_rst_n)) |=> (r_count == $past(r_count)))
        else $error("length changed without a request");

endmodule

// File: tb/indexed_list_insert_remove_tb.sv
`timescale 1ns / 100ps

module indexed_list_insert_remove_tb;
    import ilir_pkg::*;

    localparam int LIST_DEPTH = 64;

    // Op codes that the block treats as no-ops.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_FROM   = 700;

    // Flavor of a stretch of random requests.
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } t_mix;

    // One expected result item.
    typedef struct packed {
        t_status     status;
        logic [31:0] read_data;
        logic [6:0]  list_length;
    } t_list_result;

    // Tracks the list contents and checks every result item in order.
    class list_scoreboard;
        logic [31:0]  entries [LIST_DEPTH];
        int           entry_total;
        t_list_result pending_results[$];
        int           error_count;

        function new();
            entry_total = 0;
            error_count = 0;
        endfunction

        // Apply one accepted request to the tracked list and queue its result.
        function void note_request(logic [2:0] op, logic [6:0] pos, logic [31:0] value);
            t_list_result res;
            int i;
            res.status    = ST_OK;
            res.read_data = '0;
            case (op)
                OP_APPEND: begin
                    if (entry_total >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        entries[entry_total] = value;
                        entry_total++;
                    end
                end
                OP_INSERT: begin
                    if (int'(pos) > entry_total) begin
                        res.status = ST_BAD_POS;
                    end else if (entry_total >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        for (i = entry_total; i > int'(pos); i--)
                            entries[i] = entries[i - 1];
                        entries[pos] = value;
                        entry_total++;
                    end
                end
                OP_REMOVE: begin
                    if (int'(pos) >= entry_total) begin
                        res.status = ST_BAD_POS;
                    end else begin
                        for (i = int'(pos); i + 1 < entry_total; i++)
                            entries[i] = entries[i + 1];
                        entry_total--;
                    end
                end
                OP_WRITE: begin
                    if (int'(pos) >= entry_total)
                        res.status = ST_BAD_POS;
                    else
                        entries[pos] = value;
                end
                OP_READ: begin
                    if (int'(pos) >= entry_total)
                        res.status = ST_BAD_POS;
                    else
                        res.read_data = entries[pos];
                end
                default: begin
                end
            endcase
            res.list_length = 7'(entry_total);
            pending_results.push_back(res);
        endfunction

        // Compare one result item with the oldest expectation.
        function void check_result(t_list_result got);
            t_list_result want;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: unexpected result status=%0d data=%h length=%0d",
                             $realtime, got.status, got.read_data, got.list_length);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.read_data !== want.read_data ||
                got.list_length !== want.list_length) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: mismatch exp status=%0d data=%h length=%0d, got status=%0d data=%h length=%0d",
                             $realtime, want.status, want.read_data, want.list_length,
                             got.status, got.read_data, got.list_length);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // Fields from bit 0 up: op, position, data_value.
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // Fields from bit 0 up: status, read_data, list_length.
    logic [47:0] m_axis_tdata;

    bit quiet_phase = 1'b0;

    list_scoreboard sb = new();

    indexed_list_insert_remove #(
        .DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Watch both channels; results are checked before new requests are noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(t_list_result'({m_axis_tdata[1:0], m_axis_tdata[33:2],
                                                m_axis_tdata[40:34]}));
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata[2:0], s_axis_tdata[9:3], s_axis_tdata[41:10]);
        end
    end

    // Result receiver with random stall bursts until the quiet phase.
    initial begin
        m_axis_tready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    // Offer one request, maybe after an idle burst, and wait until it is taken.
    task automatic issue(input logic [2:0] op, input logic [6:0] pos, input logic [31:0] value);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, value, pos, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Data with a bias toward the signed extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Position that is mostly legal for the op, sometimes out of range.
    function automatic logic [6:0] pick_position(logic [2:0] op, int count);
        int limit;
        limit = (op == OP_INSERT) ? count : count - 1;
        if ($urandom_range(0, 19) == 0)
            return 7'd64;
        if (limit >= 0 && $urandom_range(0, 9) != 0)
            return 7'($urandom_range(0, limit));
        if (limit + 1 <= 64)
            return 7'($urandom_range(limit + 1, 64));
        return 7'd64;
    endfunction

    // One random request shaped by the current mix.
    task automatic random_request(input t_mix mix);
        logic [2:0] op;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            op = 3'($urandom_range(5, 7));
        end else if (mix == MIX_GROW) begin
            op = (roll < 50) ? OP_APPEND : (roll < 85) ? OP_INSERT :
                 (roll < 92) ? OP_READ : (roll < 97) ? OP_WRITE : OP_REMOVE;
        end else if (mix == MIX_SHRINK) begin
            op = (roll < 65) ? OP_REMOVE : (roll < 80) ? OP_READ :
                 (roll < 88) ? OP_WRITE : (roll < 94) ? OP_APPEND : OP_INSERT;
        end else begin
            op = 3'($urandom_range(0, 4));
        end
        issue(op, pick_position(op, sb.entry_total), pick_value());
    endtask

    initial begin
        int sent;
        int stretch;
        t_mix mix;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list, boundary positions, extremes of data and spare op codes.
        issue(OP_READ,   7'd0,  32'h0);
        issue(OP_REMOVE, 7'd0,  32'h0);
        issue(OP_WRITE,  7'd0,  32'h1);
        issue(OP_INSERT, 7'd1,  32'h2);
        issue(OP_INSERT, 7'd0,  32'h7FFF_FFFF);
        issue(OP_APPEND, 7'd64, 32'h8000_0000);
        issue(OP_APPEND, 7'd0,  32'hFFFF_FFFF);
        issue(OP_APPEND, 7'd0,  32'h0);
        issue(OP_READ,   7'd0,  32'hFFFF_FFFF);
        issue(OP_READ,   7'd3,  32'h0);
        issue(OP_READ,   7'd4,  32'h0);
        issue(OP_WRITE,  7'd1,  32'h5555_5555);
        issue(OP_INSERT, 7'd4,  32'hAAAA_AAAA);
        issue(OP_READ,   7'd1,  32'h0);
        issue(OP_READ,   7'd4,  32'h0);
        issue(OP_INSERT, 7'd2,  32'h1234_5678);
        issue(OP_REMOVE, 7'd0,  32'hFFFF_FFFF);
        issue(OP_REMOVE, 7'd4,  32'h0);
        issue(OP_READ,   7'd64, 32'h0);
        issue(OP_INSERT, 7'd64, 32'h3);
        issue(OP_SPARE_5, 7'd64, 32'hFFFF_FFFF);
        issue(OP_SPARE_6, 7'd1,  32'h8000_0000);
        issue(OP_SPARE_7, 7'd0,  32'h0);
        issue(OP_READ,   7'd2,  32'h0);

        // Random stretches; the first one fills the list past full.
        sent = 0;
        mix = MIX_GROW;
        stretch = 100;
        while (sent < RANDOM_ITEMS) begin
            repeat (stretch) begin
                if (sent < RANDOM_ITEMS) begin
                    quiet_phase = (sent >= QUIET_FROM);
                    random_request(mix);
                    sent++;
                end
            end
            mix = t_mix'($urandom_range(0, 2));
            stretch = $urandom_range(20, 90);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (sb.error_count == 0 && sb.pending_results.size() == 0)
            $display("** indexed_list_insert_remove: PASSED **");
        else
            $display("** indexed_list_insert_remove: FAILED **");
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #2_000_000;
        $display("** indexed_list_insert_remove: FAILED **");
        $finish;
    end

endmodule
